>>> rtl/spi_pkg.sv
// ----------------------------------------------------------------------------
// spi_pkg
// Shared widths, types, outcome codes and tolerance helpers for the segment
// pair intersection block.
// ----------------------------------------------------------------------------
package spi_pkg;

    // Coordinate format
    localparam int COORD_W   = 32;
    localparam int FRAC_W    = 16;
    localparam int EPS_W     = 16;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;

    // Derived widths
    localparam int DIFF_W = COORD_W + 1;       // difference of two coordinates
    localparam int MUL_W  = 2 * COORD_W;       // slope times coordinate
    localparam int NMAG_W = 2 * COORD_W;       // dividend magnitude
    localparam int NUM_W  = NMAG_W + 1;        // signed dividend
    localparam int DMAG_W = COORD_W;           // divisor magnitude
    localparam int PROD_W = 2 * COORD_W + 1;   // slope times difference
    localparam int SUM_W  = PROD_W + 1;
    localparam int YW_W   = SUM_W - FRAC_W;

    // Skid queues
    localparam int QDEPTH = 2;
    localparam int QCNT_W = 2;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [MUL_W-1:0]   mul_t;
    typedef logic signed [NUM_W-1:0]   num_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [EPS_W-1:0]          eps_t;

    typedef enum logic [2:0] {
        OC_HIT        = 3'd0,
        OC_SHARED     = 3'd1,
        OC_BOTH_VERT  = 3'd2,
        OC_PARALLEL   = 3'd3,
        OC_OUTSIDE    = 3'd4,
        OC_SATURATED  = 3'd5
    } oc_t;

    typedef struct packed {
        coord_t x1;
        coord_t y1;
        coord_t x2;
        coord_t y2;
        coord_t x3;
        coord_t y3;
        coord_t x4;
        coord_t y4;
    } spi_pair_t;

    // Classified item, front to back
    typedef struct packed {
        spi_pair_t p;
        diff_t     dxa;
        diff_t     dya;
        diff_t     dxb;
        diff_t     dyb;
        logic      va;
        logic      vb;
        logic      early;
        oc_t       early_oc;
    } spi_item_t;

    // Side data that travels with an item through the back pipeline
    typedef struct packed {
        spi_pair_t p;
        logic      va;
        logic      vb;
        logic      early;
        oc_t       early_oc;
        coord_t    slope;
        logic      sat;
        logic      par;
        coord_t    xc;
    } spi_tag_t;

    typedef struct packed {
        logic   crosses;
        coord_t x;
        coord_t y;
        oc_t    oc;
    } spi_res_t;

    // |d| < e, strict
    function automatic logic mag_lt(input diff_t d, input eps_t e);
        logic [DIFF_W-1:0] m;
        m = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
        return m < {{(DIFF_W-EPS_W){1'b0}}, e};
    endfunction

    // Zero, or within tolerance of zero
    function automatic logic near_zero(input diff_t d, input eps_t e);
        return (d == '0) || mag_lt(d, e);
    endfunction

endpackage

>>> rtl/segment_pair_intersection.sv
// ----------------------------------------------------------------------------
// segment_pair_intersection
// Decides whether two Q16.16 segments cross and reports the candidate point.
//
//   channel   handshake               payload
//   input     push / full             a_*, b_* start and end coordinates
//   result    pop / empty             crosses, cross_x, cross_y, outcome
//   config    cfg_valid / cfg_ready   cfg_data (epsilon)
//
// One pair per cycle sustained. Two pipelined 64-step dividers work in series
// (slopes, then intersection x), with further pipeline stages between and after.
// Reset clears all valid bits and sets epsilon to 7; cfg_ready is always high.
// A full result queue stalls the whole back pipeline; the front queue keeps
// taking pairs until it fills.
// ----------------------------------------------------------------------------
module segment_pair_intersection (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic signed [31:0]     a_start_x,
    input  logic signed [31:0]     a_start_y,
    input  logic signed [31:0]     a_end_x,
    input  logic signed [31:0]     a_end_y,
    input  logic signed [31:0]     b_start_x,
    input  logic signed [31:0]     b_start_y,
    input  logic signed [31:0]     b_end_x,
    input  logic signed [31:0]     b_end_y,
    output logic                   empty,
    input  logic                   pop,
    output logic                   crosses,
    output logic signed [31:0]     cross_x,
    output logic signed [31:0]     cross_y,
    output logic [2:0]             outcome,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [15:0]            cfg_data
);
    import spi_pkg::*;

    eps_t      eps_reg;
    spi_pair_t pair;
    logic      f_valid;
    logic      f_ready;
    spi_item_t f_item;
    spi_res_t  res;

    assign cfg_ready = 1'b1;

    // Hold epsilon
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg <= EPS_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            eps_reg <= cfg_data;
        end
    end

    always_comb
    begin
        pair.x1 = a_start_x;
        pair.y1 = a_start_y;
        pair.x2 = a_end_x;
        pair.y2 = a_end_y;
        pair.x3 = b_start_x;
        pair.y3 = b_start_y;
        pair.x4 = b_end_x;
        pair.y4 = b_end_y;
    end

    spi_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .eps       (eps_reg),
        .push      (push),
        .full      (full),
        .pair      (pair),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    spi_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .eps      (eps_reg),
        .in_valid (f_valid),
        .in_ready (f_ready),
        .in_item  (f_item),
        .pop      (pop),
        .empty    (empty),
        .res      (res)
    );

    assign crosses = res.crosses;
    assign cross_x = res.x;
    assign cross_y = res.y;
    assign outcome = res.oc;

endmodule

>>> rtl/spi_div.sv
// ----------------------------------------------------------------------------
// spi_div
// Pipelined restoring divider: one quotient bit per stage, truncated toward
// zero and saturated to the coordinate range. Carries a side tag in step.
// ----------------------------------------------------------------------------
module spi_div (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  spi_pkg::num_t      num,
    input  spi_pkg::diff_t     den,
    input  spi_pkg::spi_tag_t  tag_in,
    output logic               out_valid,
    output spi_pkg::coord_t    quo,
    output logic               quo_sat,
    output spi_pkg::spi_tag_t  tag_out
);
    import spi_pkg::*;

    // Stage 0 holds operands, stage k holds the state after k steps
    logic [NMAG_W+1:0]   v_reg;
    logic [NMAG_W-1:0]   n_reg   [NMAG_W];
    logic [DMAG_W-1:0]   r_reg   [NMAG_W];
    logic [DMAG_W-1:0]   d_reg   [NMAG_W+1];
    logic [COORD_W-1:0]  q_reg   [NMAG_W+1];
    logic                ovf_reg [NMAG_W+1];
    logic                neg_reg [NMAG_W+1];
    spi_tag_t            t_reg   [NMAG_W+1];

    coord_t              quo_reg;
    logic                sat_reg;
    spi_tag_t            tout_reg;

    logic [COORD_W-1:0]  q_fin;
    logic                sat_fin;
    coord_t              quo_fin;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[NMAG_W:0], in_valid};
        end
    end

    // Take operand magnitudes and quotient sign
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= num[NUM_W-1] ? NMAG_W'(-num) : NMAG_W'(num);
            d_reg[0]   <= den[DIFF_W-1] ? DMAG_W'(-den) : DMAG_W'(den);
            r_reg[0]   <= '0;
            q_reg[0]   <= '0;
            ovf_reg[0] <= 1'b0;
            neg_reg[0] <= num[NUM_W-1] ^ den[DIFF_W-1];
            t_reg[0]   <= tag_in;
        end
    end

    // One quotient bit per stage
    for (genvar k = 0; k < NMAG_W; k++)
    begin : g_step
        logic [DMAG_W:0] trial;
        logic            ge;
        logic [DMAG_W:0] diff;

        always_comb
        begin
            trial = {r_reg[k], n_reg[k][NMAG_W-1]};
            diff  = trial - {1'b0, d_reg[k]};
            ge    = trial >= {1'b0, d_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg[k+1]   <= {q_reg[k][COORD_W-2:0], ge};
                ovf_reg[k+1] <= ovf_reg[k] | q_reg[k][COORD_W-1];
                d_reg[k+1]   <= d_reg[k];
                neg_reg[k+1] <= neg_reg[k];
                t_reg[k+1]   <= t_reg[k];
            end
        end

        if (k < NMAG_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    r_reg[k+1] <= ge ? diff[DMAG_W-1:0] : trial[DMAG_W-1:0];
                    n_reg[k+1] <= n_reg[k] << 1;
                end
            end
        end
    end

    // Apply sign and saturate
    always_comb
    begin
        q_fin = q_reg[NMAG_W];
        if (neg_reg[NMAG_W])
        begin
            sat_fin = ovf_reg[NMAG_W] || (q_fin[COORD_W-1] && (|q_fin[COORD_W-2:0]));
            quo_fin = sat_fin ? {1'b1, {(COORD_W-1){1'b0}}} : COORD_W'(-q_fin);
        end
        else
        begin
            sat_fin = ovf_reg[NMAG_W] || q_fin[COORD_W-1];
            quo_fin = sat_fin ? {1'b0, {(COORD_W-1){1'b1}}} : q_fin;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= quo_fin;
            sat_reg  <= sat_fin;
            tout_reg <= t_reg[NMAG_W];
        end
    end

    assign out_valid = v_reg[NMAG_W+1];
    assign quo       = quo_reg;
    assign quo_sat   = sat_reg;
    assign tag_out   = tout_reg;

endmodule

>>> rtl/spi_front.sv
// ----------------------------------------------------------------------------
// spi_front
// Accepts segment pairs, flags shared endpoints and vertical segments, and
// holds classified items in a two-entry queue for the back pipeline.
// ----------------------------------------------------------------------------
module spi_front (
    input  logic               clk,
    input  logic               rst_n,
    input  spi_pkg::eps_t      eps,
    input  logic               push,
    output logic               full,
    input  spi_pkg::spi_pair_t pair,
    output logic               out_valid,
    input  logic               out_ready,
    output spi_pkg::spi_item_t out_item
);
    import spi_pkg::*;

    spi_item_t            item_in;
    logic                 shared;
    logic                 wr;
    logic                 rd;

    spi_item_t            entry_reg [QDEPTH];
    logic [QCNT_W-1:0]    cnt_reg;
    logic [QCNT_W-1:0]    cnt_next;
    logic                 wr_ptr_reg;
    logic                 rd_ptr_reg;

    // Classify the incoming pair
    always_comb
    begin
        item_in     = '0;
        item_in.p   = pair;
        item_in.dxa = DIFF_W'(pair.x2) - DIFF_W'(pair.x1);
        item_in.dya = DIFF_W'(pair.y2) - DIFF_W'(pair.y1);
        item_in.dxb = DIFF_W'(pair.x4) - DIFF_W'(pair.x3);
        item_in.dyb = DIFF_W'(pair.y4) - DIFF_W'(pair.y3);
        shared = (pair.x1 == pair.x3 && pair.y1 == pair.y3) ||
                 (pair.x1 == pair.x4 && pair.y1 == pair.y4) ||
                 (pair.x2 == pair.x3 && pair.y2 == pair.y3) ||
                 (pair.x2 == pair.x4 && pair.y2 == pair.y4);
        item_in.va       = near_zero(item_in.dxa, eps);
        item_in.vb       = near_zero(item_in.dxb, eps);
        item_in.early    = shared || (item_in.va && item_in.vb);
        item_in.early_oc = shared ? OC_SHARED : OC_BOTH_VERT;
    end

    assign full      = (cnt_reg == QCNT_W'(QDEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = entry_reg[rd_ptr_reg];
    assign wr        = push && !full;
    assign rd        = out_valid && out_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr && !rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (rd && !wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Track queue pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    // Store the classified item
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

>>> rtl/spi_back.sv
// ----------------------------------------------------------------------------
// spi_back
// Slope dividers, intercept difference, intersection divider, line
// evaluation, bounding box test and a two-entry result queue.
// ----------------------------------------------------------------------------
module spi_back (
    input  logic               clk,
    input  logic               rst_n,
    input  spi_pkg::eps_t      eps,
    input  logic               in_valid,
    output logic               in_ready,
    input  spi_pkg::spi_item_t in_item,
    input  logic               pop,
    output logic               empty,
    output spi_pkg::spi_res_t  res
);
    import spi_pkg::*;

    logic adv;

    // Slope dividers
    num_t     num_a;
    num_t     num_b;
    spi_tag_t tag_s_in;
    logic     s_v;
    coord_t   qa;
    coord_t   qb;
    logic     sa;
    logic     sb;
    spi_tag_t ts;

    // Stage registers
    logic     p1_v_reg;
    spi_tag_t p1_t_reg;
    mul_t     p1_pa_reg;
    mul_t     p1_pb_reg;
    diff_t    p1_yd_reg;
    diff_t    p1_dq_reg;
    spi_tag_t t1;

    logic     p2_v_reg;
    spi_tag_t p2_t_reg;
    num_t     p2_n_reg;
    diff_t    p2_d_reg;

    logic     x_v;
    coord_t   qx;
    logic     sx;
    spi_tag_t tx;

    logic     p3_v_reg;
    spi_tag_t p3_t_reg;
    diff_t    p3_dx_reg;
    spi_tag_t t3;
    coord_t   px;

    logic     p4_v_reg;
    spi_tag_t p4_t_reg;
    prod_t    p4_prod_reg;

    logic     p5_v_reg;
    spi_tag_t p5_t_reg;
    coord_t   p5_y_reg;
    coord_t   py;
    sum_t     ysum;
    logic [YW_W-1:0] yw;
    logic     yovf;
    coord_t   yc;
    spi_tag_t t5;

    logic     p6_v_reg;
    spi_tag_t p6_t_reg;
    coord_t   p6_y_reg;
    diff_t    p6_dd_reg [4];
    diff_t    p6_d0_reg [4];
    diff_t    p6_d1_reg [4];
    coord_t   ap [4];
    coord_t   ae0 [4];
    coord_t   ae1 [4];

    logic     res_v_reg;
    spi_res_t res_reg;
    spi_res_t res_c;
    logic     in_box;

    spi_res_t          fifo_reg [QDEPTH];
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              wr_ptr_reg;
    logic              rd_ptr_reg;
    logic              room;
    logic              fifo_wr;
    logic              fifo_rd;

    // Candidate within the bounds of one axis
    function automatic logic axis_ok(input diff_t dd, input diff_t d0, input diff_t d1,
                                     input eps_t e);
        diff_t dlo;
        diff_t dhi;
        logic  ok;
        dlo = dd[DIFF_W-1] ? d1 : d0;
        dhi = dd[DIFF_W-1] ? d0 : d1;
        if (mag_lt(dd, e))
        begin
            ok = mag_lt(dlo, e);
        end
        else
        begin
            ok = !dlo[DIFF_W-1] && (dhi[DIFF_W-1] || dhi == '0);
        end
        return ok;
    endfunction

    // Stall everything when the result queue cannot take the last stage
    assign room     = (cnt_reg != QCNT_W'(QDEPTH));
    assign adv      = !res_v_reg || room;
    assign in_ready = adv;

    // Feed slope dividers
    always_comb
    begin
        num_a             = num_t'(in_item.dya) <<< FRAC_W;
        num_b             = num_t'(in_item.dyb) <<< FRAC_W;
        tag_s_in          = '0;
        tag_s_in.p        = in_item.p;
        tag_s_in.va       = in_item.va;
        tag_s_in.vb       = in_item.vb;
        tag_s_in.early    = in_item.early;
        tag_s_in.early_oc = in_item.early_oc;
    end

    spi_div u_div_a (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .num       (num_a),
        .den       (in_item.dxa),
        .tag_in    (tag_s_in),
        .out_valid (s_v),
        .quo       (qa),
        .quo_sat   (sa),
        .tag_out   (ts)
    );

    spi_div u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (in_valid),
        .num       (num_b),
        .den       (in_item.dxb),
        .tag_in    (tag_s_in),
        .out_valid (),
        .quo       (qb),
        .quo_sat   (sb),
        .tag_out   ()
    );

    // Pick the working slope, test for parallel lines
    always_comb
    begin
        t1       = ts;
        t1.slope = ts.va ? qb : qa;
        t1.sat   = ts.va ? sb : (ts.vb ? sa : (sa | sb));
        t1.par   = !ts.va && !ts.vb && near_zero(DIFF_W'(qa) - DIFF_W'(qb), eps);
        t1.xc    = ts.va ? ts.p.x1 : ts.p.x3;
    end

    // Slope products for the intercept difference
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_t_reg  <= t1;
            p1_pa_reg <= mul_t'(qa) * mul_t'(ts.p.x1);
            p1_pb_reg <= mul_t'(qb) * mul_t'(ts.p.x3);
            p1_yd_reg <= DIFF_W'(ts.p.y3) - DIFF_W'(ts.p.y1);
            p1_dq_reg <= DIFF_W'(qa) - DIFF_W'(qb);
        end
    end

    // Intercept difference b2 - b1
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p2_t_reg <= p1_t_reg;
            p2_n_reg <= num_t'(p1_pa_reg) - num_t'(p1_pb_reg)
                        + (num_t'(p1_yd_reg) <<< FRAC_W);
            p2_d_reg <= p1_dq_reg;
        end
    end

    spi_div u_div_x (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (p2_v_reg),
        .num       (p2_n_reg),
        .den       (p2_d_reg),
        .tag_in    (p2_t_reg),
        .out_valid (x_v),
        .quo       (qx),
        .quo_sat   (sx),
        .tag_out   (tx)
    );

    // Settle the candidate x and its offset from the line's base point
    always_comb
    begin
        t3 = tx;
        if (!tx.early && !tx.va && !tx.vb && !tx.par)
        begin
            t3.xc  = qx;
            t3.sat = tx.sat | sx;
        end
        px = tx.va ? tx.p.x3 : tx.p.x1;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p3_t_reg  <= t3;
            p3_dx_reg <= DIFF_W'(t3.xc) - DIFF_W'(px);
        end
    end

    // Slope times x offset
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p4_t_reg    <= p3_t_reg;
            p4_prod_reg <= prod_t'(p3_t_reg.slope) * prod_t'(p3_dx_reg);
        end
    end

    // Add base y, floor to the coordinate grid, saturate
    always_comb
    begin
        py   = p4_t_reg.va ? p4_t_reg.p.y3 : p4_t_reg.p.y1;
        ysum = sum_t'(p4_prod_reg) + (sum_t'(py) <<< FRAC_W);
        yw   = ysum[SUM_W-1:FRAC_W];
        yovf = !((&yw[YW_W-1:COORD_W-1]) || !(|yw[YW_W-1:COORD_W-1]));
        if (yovf)
        begin
            yc = yw[YW_W-1] ? {1'b1, {(COORD_W-1){1'b0}}} : {1'b0, {(COORD_W-1){1'b1}}};
        end
        else
        begin
            yc = yw[COORD_W-1:0];
        end
        t5     = p4_t_reg;
        t5.sat = p4_t_reg.sat | yovf;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p5_t_reg <= t5;
            p5_y_reg <= yc;
        end
    end

    // Axis offsets for the box test
    always_comb
    begin
        ap[0] = p5_t_reg.xc;  ae0[0] = p5_t_reg.p.x1;  ae1[0] = p5_t_reg.p.x2;
        ap[1] = p5_y_reg;     ae0[1] = p5_t_reg.p.y1;  ae1[1] = p5_t_reg.p.y2;
        ap[2] = p5_t_reg.xc;  ae0[2] = p5_t_reg.p.x3;  ae1[2] = p5_t_reg.p.x4;
        ap[3] = p5_y_reg;     ae0[3] = p5_t_reg.p.y3;  ae1[3] = p5_t_reg.p.y4;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p6_t_reg <= p5_t_reg;
            p6_y_reg <= p5_y_reg;
            for (int i = 0; i < 4; i++)
            begin
                p6_dd_reg[i] <= DIFF_W'(ae1[i]) - DIFF_W'(ae0[i]);
                p6_d0_reg[i] <= DIFF_W'(ap[i]) - DIFF_W'(ae0[i]);
                p6_d1_reg[i] <= DIFF_W'(ap[i]) - DIFF_W'(ae1[i]);
            end
        end
    end

    // Form the result
    always_comb
    begin
        in_box = 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            in_box = in_box & axis_ok(p6_dd_reg[i], p6_d0_reg[i], p6_d1_reg[i], eps);
        end
        res_c.x = p6_t_reg.xc;
        res_c.y = p6_y_reg;
        if (p6_t_reg.early)
        begin
            res_c.oc = p6_t_reg.early_oc;
            res_c.x  = '0;
            res_c.y  = '0;
        end
        else if (p6_t_reg.par)
        begin
            res_c.oc = OC_PARALLEL;
            res_c.x  = '0;
            res_c.y  = '0;
        end
        else if (p6_t_reg.sat)
        begin
            res_c.oc = OC_SATURATED;
        end
        else if (in_box)
        begin
            res_c.oc = OC_HIT;
        end
        else
        begin
            res_c.oc = OC_OUTSIDE;
        end
        res_c.crosses = (res_c.oc == OC_HIT);
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            res_reg <= res_c;
        end
    end

    // Advance stage valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_v_reg  <= 1'b0;
            p2_v_reg  <= 1'b0;
            p3_v_reg  <= 1'b0;
            p4_v_reg  <= 1'b0;
            p5_v_reg  <= 1'b0;
            p6_v_reg  <= 1'b0;
            res_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_v_reg  <= s_v;
            p2_v_reg  <= p1_v_reg;
            p3_v_reg  <= x_v;
            p4_v_reg  <= p3_v_reg;
            p5_v_reg  <= p4_v_reg;
            p6_v_reg  <= p5_v_reg;
            res_v_reg <= p6_v_reg;
        end
    end

    // Result queue
    assign fifo_wr = res_v_reg && room;
    assign empty   = (cnt_reg == '0);
    assign fifo_rd = pop && !empty;
    assign res     = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (fifo_wr && !fifo_rd)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (fifo_rd && !fifo_wr)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg    <= '0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (fifo_wr)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (fifo_rd)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (fifo_wr)
        begin
            fifo_reg[wr_ptr_reg] <= res_reg;
        end
    end

endmodule
